@@ hdl/fwtls_pkg.sv @@
`timescale 1ns / 1ps

package fwtls_pkg;

    // Defaults of the top-level parameters
    localparam int FWTLS_APPROACHES = 4;
    localparam int FWTLS_COUNT_BITS = 24;

    // Fixed field widths on the ports
    localparam int LAMP_W     = 4;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_STEADY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAUTION_HALF = 2'd3;

    // Register reset values, cut to the counter width where they are used
    localparam logic [31:0] GREEN_STEADY_RST = 32'd450000;
    localparam logic [31:0] BLINK_HALF_RST   = 32'd62500;
    localparam logic [31:0] HOLD_RST         = 32'd250000;
    localparam logic [31:0] CAUTION_HALF_RST = 32'h0000_2DC6;

    // Gesture stages
    localparam int GST_W = 3;
    localparam logic [GST_W-1:0] GST_IDLE      = 3'd0;
    localparam logic [GST_W-1:0] GST_HOLD_A    = 3'd1;
    localparam logic [GST_W-1:0] GST_WAIT_B    = 3'd2;
    localparam logic [GST_W-1:0] GST_HOLD_AB   = 3'd3;
    localparam logic [GST_W-1:0] GST_RELEASE_B = 3'd4;
    localparam logic [GST_W-1:0] GST_RELEASE_A = 3'd5;

    // Sequence steps of one approach
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_STEADY    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_GREEN_END = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LAST      = 4'd10;

endpackage

@@ hdl/four_way_traffic_light_sequencer.sv @@
`timescale 1ns / 1ps

// Channel  | Ports                       | Contents (low bit up)
// ---------+-----------------------------+------------------------------------------
// tick in  | s_tvalid s_tready s_tdata   | [0] button_a_pressed, [1] button_b_pressed
// lamps out| m_tvalid m_tready m_tdata   | [3:0] green, [7:4] yellow, [11:8] red,
//          |                             | [12] caution_active
// config   | cfg_we cfg_index cfg_wdata  | register index, 24-bit value
//
// One request per clock unless stalled; the lamps for a tick leave in the next cycle.
// The result register frees when the sink takes its request, so s_tready stays high
// while m_tready is high. A stalled sink holds m_tdata and blocks new ticks.
// Reset clears the sequence, gesture and mode, and reloads the interval registers.

module four_way_traffic_light_sequencer
    import fwtls_pkg::*;
#(
    parameter int APPROACHES = FWTLS_APPROACHES,
    parameter int COUNT_BITS = FWTLS_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // button_a_pressed, button_b_pressed
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // green_lamps, yellow_lamps, red_lamps,
                                             // caution_active
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AIDX_W = $clog2(APPROACHES);
    localparam int PAD_W  = M_TDATA_W - 3 * LAMP_W - 1;

    logic [COUNT_BITS-1:0] green_steady_reg;
    logic [COUNT_BITS-1:0] blink_half_reg;
    logic [COUNT_BITS-1:0] hold_len_reg;
    logic [COUNT_BITS-1:0] caution_half_reg;

    logic                  caution_reg,   caution_next;
    logic [AIDX_W-1:0]     approach_reg,  approach_next;
    logic [STEP_W-1:0]     step_reg,      step_next;
    logic [COUNT_BITS-1:0] interval_reg,  interval_next;
    logic [GST_W-1:0]      gesture_reg,   gesture_next;
    logic [COUNT_BITS-1:0] hold_cnt_reg,  hold_cnt_next;
    logic                  yellow_on_reg, yellow_on_next;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic                  accept;
    logic                  btn_a;
    logic                  btn_b;
    logic [31:0]           cfg_ext;
    logic [LAMP_W-1:0]     lamp_mask;
    logic [LAMP_W-1:0]     active_bit;
    logic [LAMP_W-1:0]     green_lamps;
    logic [LAMP_W-1:0]     yellow_lamps;
    logic [LAMP_W-1:0]     red_lamps;
    logic [STEP_W-1:0]     step_clamped;
    logic [COUNT_BITS-1:0] interval_len;
    logic [COUNT_BITS:0]   interval_inc;
    logic                  interval_hit;
    logic [COUNT_BITS:0]   hold_inc;
    logic                  hold_hit;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign btn_a    = s_tdata[0];
    assign btn_b    = s_tdata[1];
    assign cfg_ext  = {{(32 - CFG_DATA_W){1'b0}}, cfg_wdata};
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Lamps from the state held before this tick's update
    always_comb begin
        for (int k = 0; k < LAMP_W; k++) begin
            lamp_mask[k]  = (k < APPROACHES);
            active_bit[k] = (k < APPROACHES) && (approach_reg == AIDX_W'(k));
        end
        step_clamped = (step_reg > STEP_LAST) ? STEP_LAST : step_reg;
        green_lamps  = '0;
        yellow_lamps = '0;
        red_lamps    = '0;
        if (caution_reg) begin
            yellow_lamps = yellow_on_reg ? lamp_mask : '0;
        end else begin
            red_lamps = lamp_mask & ~active_bit;
            if (step_clamped <= STEP_GREEN_END) begin
                if (!step_clamped[0]) begin
                    green_lamps = active_bit;
                end
            end else if (step_clamped[0]) begin
                yellow_lamps = active_bit;
            end
        end
    end

    // Interval and hold counters; a zero length behaves as one
    always_comb begin
        if (caution_reg) begin
            interval_len = caution_half_reg;
        end else if (step_reg == STEP_STEADY) begin
            interval_len = green_steady_reg;
        end else begin
            interval_len = blink_half_reg;
        end
        interval_inc = {1'b0, interval_reg} + (COUNT_BITS + 1)'(1);
        interval_hit = interval_inc >= {1'b0, interval_len};
        hold_inc     = {1'b0, hold_cnt_reg} + (COUNT_BITS + 1)'(1);
        hold_hit     = hold_inc >= {1'b0, hold_len_reg};
    end

    always_comb begin
        caution_next   = caution_reg;
        approach_next  = approach_reg;
        step_next      = step_reg;
        interval_next  = interval_reg;
        gesture_next   = gesture_reg;
        hold_cnt_next  = hold_cnt_reg;
        yellow_on_next = yellow_on_reg;

        case (gesture_reg)
            GST_IDLE: begin
                if (btn_a) begin
                    gesture_next  = GST_HOLD_A;
                    hold_cnt_next = '0;
                end
            end
            GST_HOLD_A: begin
                if (!btn_a) begin
                    gesture_next = GST_IDLE;
                end else if (hold_hit) begin
                    gesture_next  = GST_WAIT_B;
                    hold_cnt_next = '0;
                end else begin
                    hold_cnt_next = hold_inc[COUNT_BITS-1:0];
                end
            end
            GST_WAIT_B: begin
                if (btn_b) begin
                    gesture_next  = GST_HOLD_AB;
                    hold_cnt_next = '0;
                end
            end
            GST_HOLD_AB: begin
                if (!(btn_a && btn_b)) begin
                    gesture_next = GST_IDLE;
                end else if (hold_hit) begin
                    gesture_next  = GST_RELEASE_B;
                    hold_cnt_next = '0;
                end else begin
                    hold_cnt_next = hold_inc[COUNT_BITS-1:0];
                end
            end
            GST_RELEASE_B: begin
                if (!btn_b) begin
                    gesture_next = btn_a ? GST_RELEASE_A : GST_IDLE;
                end
            end
            GST_RELEASE_A: begin
                if (!btn_a) begin
                    gesture_next   = GST_IDLE;
                    caution_next   = !caution_reg;
                    interval_next  = '0;
                    yellow_on_next = 1'b0;
                    approach_next  = '0;
                    step_next      = STEP_STEADY;
                end
            end
            default: begin
                gesture_next = GST_IDLE;
            end
        endcase

        // The lights move only while no gesture is under way
        if (gesture_reg == GST_IDLE && gesture_next == GST_IDLE) begin
            interval_next = interval_hit ? '0 : interval_inc[COUNT_BITS-1:0];
            if (interval_hit) begin
                if (caution_reg) begin
                    yellow_on_next = !yellow_on_reg;
                end else if (step_reg >= STEP_LAST) begin
                    step_next     = STEP_STEADY;
                    approach_next = (approach_reg == AIDX_W'(APPROACHES - 1)) ?
                                    '0 : approach_reg + AIDX_W'(1);
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            green_steady_reg <= GREEN_STEADY_RST[COUNT_BITS-1:0];
            blink_half_reg   <= BLINK_HALF_RST[COUNT_BITS-1:0];
            hold_len_reg     <= HOLD_RST[COUNT_BITS-1:0];
            caution_half_reg <= CAUTION_HALF_RST[COUNT_BITS-1:0];
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GREEN_STEADY: green_steady_reg <= cfg_ext[COUNT_BITS-1:0];
                REG_BLINK_HALF:   blink_half_reg   <= cfg_ext[COUNT_BITS-1:0];
                REG_HOLD:         hold_len_reg     <= cfg_ext[COUNT_BITS-1:0];
                REG_CAUTION_HALF: caution_half_reg <= cfg_ext[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            caution_reg   <= 1'b0;
            approach_reg  <= '0;
            step_reg      <= STEP_STEADY;
            interval_reg  <= '0;
            gesture_reg   <= GST_IDLE;
            hold_cnt_reg  <= '0;
            yellow_on_reg <= 1'b0;
        end else if (accept) begin
            caution_reg   <= caution_next;
            approach_reg  <= approach_next;
            step_reg      <= step_next;
            interval_reg  <= interval_next;
            gesture_reg   <= gesture_next;
            hold_cnt_reg  <= hold_cnt_next;
            yellow_on_reg <= yellow_on_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, caution_reg, red_lamps, yellow_lamps, green_lamps};
        end
    end

endmodule

@@ hdl/fwtls_checker.sv @@
`timescale 1ns / 1ps

module fwtls_checker
    import fwtls_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    logic [LAMP_W-1:0] green;
    logic [LAMP_W-1:0] yellow;
    logic [LAMP_W-1:0] red;
    logic              caution;

    assign green   = m_tdata[LAMP_W-1:0];
    assign yellow  = m_tdata[2*LAMP_W-1:LAMP_W];
    assign red     = m_tdata[3*LAMP_W-1:2*LAMP_W];
    assign caution = m_tdata[3*LAMP_W];

    // A stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("lamp request changed while stalled");

    // A taken result with no new request behind it leaves the output empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("lamp request repeated after it was taken");

    // Caution mode shows yellows only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && caution |-> green == '0 && red == '0)
        else $error("green or red lit in caution mode");

    // Normal mode: a lit green or yellow never shares an approach with red
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !caution |-> ((green | yellow) & red) == '0)
        else $error("red lit together with green or yellow");

    // Normal mode: at most one approach has green or yellow
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !caution |-> $onehot0(green | yellow))
        else $error("more than one approach released");

endmodule

bind four_way_traffic_light_sequencer fwtls_checker u_fwtls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import fwtls_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENT_CAP    = 40;   // cap on the hold span that a gesture drives
    localparam logic [CFG_DATA_W-1:0] LEN_MAX = '1;

    // m_tdata layout, low bit up: green, yellow, red, caution_active, zero fill
    typedef struct packed {
        logic [2:0]        spare;
        logic              caution;
        logic [LAMP_W-1:0] red;
        logic [LAMP_W-1:0] yellow;
        logic [LAMP_W-1:0] green;
    } lamp_word_t;

    class lamp_scoreboard;
        logic [CFG_DATA_W-1:0] green_len;
        logic [CFG_DATA_W-1:0] blink_len;
        logic [CFG_DATA_W-1:0] hold_len;
        logic [CFG_DATA_W-1:0] caution_len;
        bit                    caution;
        bit [1:0]              approach;
        bit [STEP_W-1:0]       step;
        bit [CFG_DATA_W-1:0]   interval_cnt;
        bit [GST_W-1:0]        stage;
        bit [CFG_DATA_W-1:0]   hold_cnt;
        bit                    yellow_on;
        lamp_word_t            expected_lamps[$];
        int                    errors;
        int                    checked;
        int                    toggles;

        function new();
            green_len   = GREEN_STEADY_RST[CFG_DATA_W-1:0];
            blink_len   = BLINK_HALF_RST[CFG_DATA_W-1:0];
            hold_len    = HOLD_RST[CFG_DATA_W-1:0];
            caution_len = CAUTION_HALF_RST[CFG_DATA_W-1:0];
        endfunction

        function void set_length(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_GREEN_STEADY: green_len = v;
                REG_BLINK_HALF:   blink_len = v;
                REG_HOLD:         hold_len = v;
                REG_CAUTION_HALF: caution_len = v;
                default: ;
            endcase
        endfunction

        // a zero length ends after one tick, same as a length of one
        function bit interval_done(inout bit [CFG_DATA_W-1:0] cnt,
                                   input logic [CFG_DATA_W-1:0] len);
            bit [CFG_DATA_W:0] nxt;
            nxt = cnt + 1'b1;
            if (nxt >= {1'b0, len}) begin
                cnt = '0;
                return 1'b1;
            end
            cnt = nxt[CFG_DATA_W-1:0];
            return 1'b0;
        endfunction

        function void note_tick(bit a, bit b);
            lamp_word_t        w;
            logic [LAMP_W-1:0] lit;
            logic [STEP_W-1:0] s;
            bit                was_idle;

            // lamps show the state from before this tick
            w = '0;
            w.caution = caution;
            if (caution) begin
                w.yellow = {LAMP_W{yellow_on}};
            end else begin
                lit = '0;
                lit[approach] = 1'b1;
                w.red = ~lit;
                s = (step > STEP_LAST) ? STEP_LAST : step;
                if (s <= STEP_GREEN_END) begin
                    if (!s[0]) w.green = lit;
                end else if (s[0]) begin
                    w.yellow = lit;
                end
            end
            expected_lamps.push_back(w);

            was_idle = (stage == GST_IDLE);
            case (stage)
                GST_IDLE: begin
                    if (a) begin
                        stage = GST_HOLD_A;
                        hold_cnt = '0;
                    end
                end
                GST_HOLD_A: begin
                    if (!a) stage = GST_IDLE;
                    else if (interval_done(hold_cnt, hold_len)) stage = GST_WAIT_B;
                end
                GST_WAIT_B: begin
                    if (b) begin
                        stage = GST_HOLD_AB;
                        hold_cnt = '0;
                    end
                end
                GST_HOLD_AB: begin
                    if (!(a && b)) stage = GST_IDLE;
                    else if (interval_done(hold_cnt, hold_len)) stage = GST_RELEASE_B;
                end
                GST_RELEASE_B: begin
                    if (!b) stage = a ? GST_RELEASE_A : GST_IDLE;
                end
                GST_RELEASE_A: begin
                    if (!a) begin
                        stage = GST_IDLE;
                        caution = !caution;
                        toggles++;
                        interval_cnt = '0;
                        yellow_on = 1'b0;
                        approach = '0;
                        step = STEP_STEADY;
                    end
                end
                default: stage = GST_IDLE;
            endcase

            // lights move only while no gesture is in progress
            if (was_idle && stage == GST_IDLE) begin
                if (caution) begin
                    if (interval_done(interval_cnt, caution_len)) yellow_on = !yellow_on;
                end else if (interval_done(interval_cnt,
                                           step == STEP_STEADY ? green_len : blink_len)) begin
                    if (step >= STEP_LAST) begin
                        step = STEP_STEADY;
                        approach++;
                    end else begin
                        step++;
                    end
                end
            end
        endfunction

        function void check_lamps(logic [M_TDATA_W-1:0] raw);
            lamp_word_t got;
            lamp_word_t want;
            got = raw;
            if (expected_lamps.size() == 0) begin
                $error("lamp word %h arrived with no tick outstanding", raw);
                errors++;
                return;
            end
            want = expected_lamps.pop_front();
            checked++;
            if (got.green !== want.green) begin
                $error("green_lamps: expected %h, actual %h", want.green, got.green);
                errors++;
            end
            if (got.yellow !== want.yellow) begin
                $error("yellow_lamps: expected %h, actual %h", want.yellow, got.yellow);
                errors++;
            end
            if (got.red !== want.red) begin
                $error("red_lamps: expected %h, actual %h", want.red, got.red);
                errors++;
            end
            if (got.caution !== want.caution) begin
                $error("caution_active: expected %b, actual %b", want.caution, got.caution);
                errors++;
            end
            if (got.spare !== want.spare) begin
                $error("tdata fill: expected %h, actual %h", want.spare, got.spare);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // button_a_pressed, button_b_pressed
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // green_lamps, yellow_lamps, red_lamps,
                                           // caution_active
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lamp_scoreboard lamps_sb;
    int unsigned    idle_pct = 0;
    int unsigned    stall_pct = 0;
    int unsigned    ticks_sent = 0;
    int unsigned    quiet_cycles = 0;

    four_way_traffic_light_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) lamps_sb.check_lamps(m_tdata);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("four_way_traffic_light_sequencer verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic tick(bit a, bit b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-2){1'b0}}, b, a};
        do @(posedge aclk); while (!s_tready);
        lamps_sb.note_tick(a, b);
        ticks_sent++;
    endtask

    // hold off new requests until every lamp word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (lamps_sb.expected_lamps.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        lamps_sb.set_length(idx, v);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] bl,
                             logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] c);
        write_reg(REG_GREEN_STEADY, g);
        write_reg(REG_BLINK_HALF, bl);
        write_reg(REG_HOLD, h);
        write_reg(REG_CAUTION_HALF, c);
        cfg_we <= 1'b0;
    endtask

    // A, then A+B, then drop B, then drop A; a broken one bails out early
    task automatic gesture(bit broken);
        int unsigned hold_span;
        int unsigned cut;
        int unsigned pick;
        if (lamps_sb.hold_len > SEGMENT_CAP) hold_span = SEGMENT_CAP;
        else hold_span = (lamps_sb.hold_len == 0) ? 1 : lamps_sb.hold_len;
        cut = broken ? $urandom_range(2) : 3;

        if (cut == 0) begin
            repeat ($urandom_range(1, hold_span)) tick(1'b1, 1'b0);
            tick(1'b0, 1'($urandom_range(1)));
            return;
        end
        repeat (hold_span + 1 + $urandom_range(2)) tick(1'b1, 1'b0);
        repeat ($urandom_range(3)) tick(1'($urandom_range(1)), 1'b0);

        if (cut == 1) begin
            repeat ($urandom_range(1, hold_span)) tick(1'b1, 1'b1);
            pick = $urandom_range(2);
            tick(pick[0], pick[1]);
            return;
        end
        repeat (hold_span + 1 + $urandom_range(2)) tick(1'b1, 1'b1);

        if (cut == 2) begin
            tick(1'b0, 1'b0);
            return;
        end
        tick(1'b1, 1'b0);
        repeat ($urandom_range(2)) tick(1'b1, 1'($urandom_range(1)));
        tick(1'b0, 1'($urandom_range(1)));
    endtask

    task automatic run_phase(int unsigned n_ticks, bit pause_midway);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                gesture(1'b0);
            end else if (pick < 75) begin
                gesture(1'b1);
            end else begin
                repeat ($urandom_range(1, 20))
                    tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            // B alone never starts a gesture, so this lets the lights run
            repeat ($urandom_range(1, 40)) tick(1'b0, 1'($urandom_range(1)));
            if (pause_midway && ticks_sent >= stop_at - n_ticks / 2) begin
                drain();
                pause_midway = 1'b0;
            end
        end
    endtask

    initial begin
        int phase;
        lamps_sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset lengths: a gesture starts and is dropped right away
        tick(1'b0, 1'b1); tick(1'b1, 1'b1); tick(1'b0, 1'b0);
        drain();

        // zero blink and caution lengths behave as one tick
        configure(2, 0, 1, 0);
        tick(1'b0, 1'b0); tick(1'b0, 1'b0); tick(1'b0, 1'b0);
        // into caution; A may come and go while waiting for B
        tick(1'b1, 1'b0); tick(1'b1, 1'b0); tick(1'b1, 1'b0); tick(1'b0, 1'b0);
        tick(1'b1, 1'b1); tick(1'b1, 1'b1); tick(1'b1, 1'b0); tick(1'b0, 1'b1);
        tick(1'b0, 1'b0); tick(1'b0, 1'b0);
        // both dropped together after the joint hold: no mode change
        tick(1'b1, 1'b0); tick(1'b1, 1'b0); tick(1'b1, 1'b1); tick(1'b1, 1'b1);
        tick(1'b0, 1'b0);
        // back to normal, sequence restarts on approach one
        tick(1'b1, 1'b0); tick(1'b1, 1'b0); tick(1'b1, 1'b1); tick(1'b1, 1'b1);
        tick(1'b1, 1'b0); tick(1'b0, 1'b0);

        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: configure(1, 1, 1, 1);
                1: configure(6, 2, 3, 2);
                2: configure(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
                3: configure(CFG_DATA_W'($urandom_range(1, 12)),
                             CFG_DATA_W'($urandom_range(1, 4)),
                             CFG_DATA_W'($urandom_range(1, 4)),
                             CFG_DATA_W'($urandom_range(1, 4)));
                4: configure(CFG_DATA_W'($urandom_range(8)),
                             CFG_DATA_W'($urandom_range(3)),
                             CFG_DATA_W'($urandom_range(3)),
                             CFG_DATA_W'($urandom_range(3)));
                default: configure(9, 3, 2, 5);
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            run_phase((phase == 2) ? 150 : 320, phase == 1);
        end
        drain();
        repeat (4) @(posedge aclk);

        $display("Sent %0d button ticks across eight length settings, zero and full scale too",
                 ticks_sent);
        $display("Checked %0d lamp words under four handshake patterns, %0d mode toggles",
                 lamps_sb.checked, lamps_sb.toggles);
        if (lamps_sb.errors == 0) begin
            $display("four_way_traffic_light_sequencer verification clean");
        end else begin
            $display("four_way_traffic_light_sequencer verification failed");
        end
        $finish;
    end

endmodule
